>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mlpbp_pkg.sv
// Types, constants and helper functions of the 2-2-1 backprop trainer.
// Depends on nothing.
package mlpbp_pkg;

  localparam int WORD_BITS       = 16;
  localparam int FRAC_BITS       = 12;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int LR_FRAC         = 12;
  localparam int IN_BITS         = 16;
  localparam int LR_BITS         = 13;
  localparam int SIG_BITS        = FRAC_BITS + 1;
  localparam int IDX_BITS        = $clog2(SIGMOID_ENTRIES);
  localparam int MUL_W           = 18;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int ACC_W           = 40;
  localparam int NUM_WEIGHTS     = 9;
  localparam int WIDX_BITS       = 4;
  localparam logic [LR_BITS-1:0] LR_RESET = 13'd819;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [IN_BITS-1:0]   in_word_t;
  typedef logic [SIG_BITS-1:0]         sig_t;
  typedef logic signed [MUL_W-1:0]     opd_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic [LR_BITS-1:0]          lr_t;
  typedef logic [WIDX_BITS-1:0]        widx_t;

  typedef enum logic [1:0] {
    MODE_TRAIN = 2'd0,
    MODE_INFER = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Weight slots
  localparam widx_t WI_X0H0 = 4'd0;
  localparam widx_t WI_X0H1 = 4'd1;
  localparam widx_t WI_X1H0 = 4'd2;
  localparam widx_t WI_X1H1 = 4'd3;
  localparam widx_t WI_B0   = 4'd4;
  localparam widx_t WI_B1   = 4'd5;
  localparam widx_t WI_V0   = 4'd6;
  localparam widx_t WI_V1   = 4'd7;
  localparam widx_t WI_C    = 4'd8;

  localparam sig_t SIG_ONE = sig_t'(1 << FRAC_BITS);

  typedef struct packed {
    opd_t a;
    opd_t b;
  } mul_req_t;

  typedef struct packed {
    logic  flag;
    word_t val;
  } sat_res_t;

  typedef logic [SIG_BITS-1:0] sig_tab_t [SIGMOID_ENTRIES];

  // Saturate a wide sum to the weight word
  function automatic sat_res_t sat_word(input acc_t v);
    sat_res_t r;
    acc_t     hi;
    acc_t     lo;
    hi = acc_t'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    lo = -hi - acc_t'(1);
    r.flag = 1'b0;
    r.val  = word_t'(v);
    if (v > hi) begin
      r.flag = 1'b1;
      r.val  = word_t'(hi);
    end else if (v < lo) begin
      r.flag = 1'b1;
      r.val  = word_t'(lo);
    end
    return r;
  endfunction

  function automatic opd_t sig_to_opd(input sig_t v);
    return opd_t'({1'b0, v});
  endfunction

  // Shift-and-subtract unsigned quotient, used only while building the table
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build the sigmoid table at elaboration
  function automatic sig_tab_t build_sig_table();
    sig_tab_t          tab;
    longint            num;
    longint            sum;
    longint unsigned   mag;
    longint unsigned   y;
    longint unsigned   t;
    longint unsigned   e;
    longint unsigned   den;
    longint unsigned   one;
    longint unsigned   q;
    one = 64'd1 << 30;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      num = 16 * i - 8 * SIGMOID_ENTRIES;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      y   = (mag << 26) >> IDX_BITS;
      t   = one;
      sum = longint'(one);
      for (int k = 1; k <= 16; k++) begin
        t = udiv((t * y) >> 30, 64'(k));
        if (k[0]) sum = sum - longint'(t);
        else      sum = sum + longint'(t);
      end
      e = longint'(sum);
      for (int k = 0; k < 4; k++) e = (e * e) >> 30;
      den = one + e;
      if (num >= 0) q = udiv((64'd1 << FRAC_BITS) * one + (den >> 1), den);
      else          q = udiv((64'd1 << FRAC_BITS) * e + (den >> 1), den);
      tab[i] = q[SIG_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

>>> hdl/mlpbp_if.sv
// Request channels of the trainer: input, result and configuration.
// Depends on mlpbp_pkg.
interface mlpbp_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  mlpbp_pkg::in_word_t     x_first;
  mlpbp_pkg::in_word_t     x_second;
  logic [12:0]             target;
  logic [3:0]              weight_index;
  mlpbp_pkg::in_word_t     weight_value;
  modport source (output valid, mode, x_first, x_second, target, weight_index,
                  weight_value, input ready);
  modport sink (input valid, mode, x_first, x_second, target, weight_index,
                weight_value, output ready);
endinterface

interface mlpbp_out_if;
  logic                valid;
  logic                ready;
  mlpbp_pkg::sig_t     net_output;
  logic                saturated;
  modport source (output valid, net_output, saturated, input ready);
  modport sink (input valid, net_output, saturated, output ready);
endinterface

interface mlpbp_cfg_if;
  logic              valid;
  logic              ready;
  mlpbp_pkg::lr_t    learning_rate;
  modport source (output valid, learning_rate, input ready);
  modport sink (input valid, learning_rate, output ready);
endinterface

>>> hdl/mlpbp_mul.sv
// Shared signed multiplier with registered product.
// Depends on mlpbp_pkg.
module mlpbp_mul (
  input  logic                clk,
  input  mlpbp_pkg::mul_req_t req,
  output mlpbp_pkg::prod_t    prod_r
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

endmodule

>>> hdl/mlpbp_sig.sv
// Pre-activation sum, saturation and sigmoid table lookup.
// Depends on mlpbp_pkg.
module mlpbp_sig (
  input  mlpbp_pkg::prod_t acc,
  input  mlpbp_pkg::prod_t prod,
  input  mlpbp_pkg::word_t bias,
  output mlpbp_pkg::sig_t  y,
  output logic             flag
);

  mlpbp_pkg::acc_t     sum;
  mlpbp_pkg::acc_t     pre;
  mlpbp_pkg::sat_res_t sres;
  mlpbp_pkg::acc_t     off;
  mlpbp_pkg::acc_t     scaled;
  logic [mlpbp_pkg::IDX_BITS-1:0] idx;

  // Sum, rescale, add bias, saturate
  always_comb begin
    sum  = mlpbp_pkg::acc_t'(acc) + mlpbp_pkg::acc_t'(prod);
    pre  = (sum >>> mlpbp_pkg::FRAC_BITS) + mlpbp_pkg::acc_t'(bias);
    sres = mlpbp_pkg::sat_word(pre);
    flag = sres.flag;
  end

  // Map onto the table index, clamped at both ends
  always_comb begin
    off    = mlpbp_pkg::acc_t'(sres.val)
             + mlpbp_pkg::acc_t'(8 << mlpbp_pkg::FRAC_BITS);
    scaled = (off * mlpbp_pkg::acc_t'(mlpbp_pkg::SIGMOID_ENTRIES))
             >>> (mlpbp_pkg::FRAC_BITS + 4);
    priority if (off < 0) begin
      idx = '0;
    end else if (scaled >= mlpbp_pkg::acc_t'(mlpbp_pkg::SIGMOID_ENTRIES)) begin
      idx = mlpbp_pkg::IDX_BITS'(mlpbp_pkg::SIGMOID_ENTRIES - 1);
    end else begin
      idx = scaled[mlpbp_pkg::IDX_BITS-1:0];
    end
    y = mlpbp_pkg::SIG_TABLE[idx];
  end

endmodule

>>> hdl/mlp_online_backprop_trainer.sv
// Top level of the 2-2-1 sigmoid network trainer: sequencer, weights, result stage.
// Depends on mlpbp_pkg, mlpbp_if, mlpbp_mul, mlpbp_sig and assert_macros.svh.
//
// A 2-input, 2-hidden, 1-output sigmoid network with nine signed Q4.12 weights
// (reset to zero). Each request picks a mode: train runs the forward pass,
// the deltas and one saturating online update, and returns the output seen
// before the update; infer runs the forward pass; load writes one weight if its index is in range.
// All products go through a single registered 18x18 multiplier stepped by a
// sequencer, one product per cycle; a request goes from IDLE straight to DONE
// (load or unused mode), through steps P0 to P6 (infer) or through P0 to P24
// (train), and from DONE its result is loaded into the output register and the
// sequencer returns to IDLE to accept the next request. The
// input is not ready while a request is being worked on; a finished result
// waits in the output register while the next request is taken, and the
// sequencer holds in its last step for as long as that register is still
// occupied. The learning rate port is always ready and must only be written
// while the block is idle.
`include "assert_macros.svh"

module mlp_online_backprop_trainer (
  input  logic              clk,
  input  logic              rst_n,
  mlpbp_in_if.sink          in_ch,
  mlpbp_out_if.source       out_ch,
  mlpbp_cfg_if.sink         cfg_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_P10, S_P11, S_P12, S_P13, S_P14, S_P15, S_P16, S_P17, S_P18, S_P19,
    S_P20, S_P21, S_P22, S_P23, S_P24, S_DONE
  } state_t;

  state_t                 state_r;
  mlpbp_pkg::mode_t       mode_r;
  mlpbp_pkg::lr_t         lr_r;
  mlpbp_pkg::word_t       wt_r [mlpbp_pkg::NUM_WEIGHTS];
  mlpbp_pkg::in_word_t    x0_r, x1_r;
  mlpbp_pkg::sig_t        tgt_r;
  mlpbp_pkg::prod_t       acc_r;
  mlpbp_pkg::sig_t        h0_r, h1_r, o_r;
  mlpbp_pkg::opd_t        dso_r, dsh0_r, dsh1_r, dout_r, t0_r, t1_r;
  mlpbp_pkg::opd_t        dh0_r, dh1_r, ko_r, kh0_r, kh1_r;
  logic                   sat_r;
  logic                   out_valid_r;
  mlpbp_pkg::sig_t        res_o_r;
  logic                   res_sat_r;

  mlpbp_pkg::mul_req_t    mreq;
  mlpbp_pkg::prod_t       prod_r;
  mlpbp_pkg::word_t       sbias;
  mlpbp_pkg::sig_t        sig_y;
  logic                   sig_flag;
  mlpbp_pkg::opd_t        prod_f;
  mlpbp_pkg::opd_t        prod_l;
  mlpbp_pkg::acc_t        prod_w;
  mlpbp_pkg::sat_res_t    upd;
  mlpbp_pkg::mode_t       in_mode;
  logic                   zero_done;
  logic                   busy;

  assign in_mode = mlpbp_pkg::mode_t'(in_ch.mode);

  // Rescaled views of the last product
  assign prod_f = mlpbp_pkg::opd_t'(prod_r >>> mlpbp_pkg::FRAC_BITS);
  assign prod_l = mlpbp_pkg::opd_t'(prod_r >>> mlpbp_pkg::LR_FRAC);
  assign prod_w = mlpbp_pkg::acc_t'(prod_r) >>> mlpbp_pkg::FRAC_BITS;

  mlpbp_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  mlpbp_sig u_sig (
    .acc  (acc_r),
    .prod (prod_r),
    .bias (sbias),
    .y    (sig_y),
    .flag (sig_flag)
  );

  // Select multiplier operands for each step
  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    unique case (state_r)
      S_P0: begin
        mreq.a = mlpbp_pkg::opd_t'(x0_r);
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_X0H0]);
      end
      S_P1: begin
        mreq.a = mlpbp_pkg::opd_t'(x1_r);
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_X1H0]);
      end
      S_P2: begin
        mreq.a = mlpbp_pkg::opd_t'(x0_r);
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_X0H1]);
      end
      S_P3: begin
        mreq.a = mlpbp_pkg::opd_t'(x1_r);
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_X1H1]);
      end
      S_P4: begin
        mreq.a = mlpbp_pkg::sig_to_opd(h0_r);
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_V0]);
      end
      S_P5: begin
        mreq.a = mlpbp_pkg::sig_to_opd(h1_r);
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_V1]);
      end
      S_P7: begin
        mreq.a = mlpbp_pkg::sig_to_opd(o_r);
        mreq.b = mlpbp_pkg::sig_to_opd(mlpbp_pkg::SIG_ONE) - mlpbp_pkg::sig_to_opd(o_r);
      end
      S_P8: begin
        mreq.a = mlpbp_pkg::sig_to_opd(h0_r);
        mreq.b = mlpbp_pkg::sig_to_opd(mlpbp_pkg::SIG_ONE) - mlpbp_pkg::sig_to_opd(h0_r);
      end
      S_P9: begin
        mreq.a = mlpbp_pkg::sig_to_opd(tgt_r) - mlpbp_pkg::sig_to_opd(o_r);
        mreq.b = dso_r;
      end
      S_P10: begin
        mreq.a = mlpbp_pkg::sig_to_opd(h1_r);
        mreq.b = mlpbp_pkg::sig_to_opd(mlpbp_pkg::SIG_ONE) - mlpbp_pkg::sig_to_opd(h1_r);
      end
      S_P11: begin
        mreq.a = dout_r;
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_V0]);
      end
      S_P12: begin
        mreq.a = dout_r;
        mreq.b = mlpbp_pkg::opd_t'(wt_r[mlpbp_pkg::WI_V1]);
      end
      S_P13: begin
        mreq.a = t0_r;
        mreq.b = dsh0_r;
      end
      S_P14: begin
        mreq.a = t1_r;
        mreq.b = dsh1_r;
      end
      S_P15: begin
        mreq.a = mlpbp_pkg::opd_t'(lr_r);
        mreq.b = dout_r;
      end
      S_P16: begin
        mreq.a = mlpbp_pkg::opd_t'(lr_r);
        mreq.b = dh0_r;
      end
      S_P17: begin
        mreq.a = mlpbp_pkg::opd_t'(lr_r);
        mreq.b = dh1_r;
      end
      S_P18: begin
        mreq.a = ko_r;
        mreq.b = mlpbp_pkg::sig_to_opd(h0_r);
      end
      S_P19: begin
        mreq.a = ko_r;
        mreq.b = mlpbp_pkg::sig_to_opd(h1_r);
      end
      S_P20: begin
        mreq.a = kh0_r;
        mreq.b = mlpbp_pkg::opd_t'(x0_r);
      end
      S_P21: begin
        mreq.a = kh0_r;
        mreq.b = mlpbp_pkg::opd_t'(x1_r);
      end
      S_P22: begin
        mreq.a = kh1_r;
        mreq.b = mlpbp_pkg::opd_t'(x0_r);
      end
      S_P23: begin
        mreq.a = kh1_r;
        mreq.b = mlpbp_pkg::opd_t'(x1_r);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  // Pick the bias for the sigmoid sum
  always_comb begin
    unique case (state_r)
      S_P2:    sbias = wt_r[mlpbp_pkg::WI_B0];
      S_P4:    sbias = wt_r[mlpbp_pkg::WI_B1];
      default: sbias = wt_r[mlpbp_pkg::WI_C];
    endcase
  end

  // Saturating weight update for the current step
  always_comb begin
    unique case (state_r)
      S_P18:   upd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_C])
                                         + mlpbp_pkg::acc_t'(ko_r));
      S_P19:   upd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_V0]) + prod_w);
      S_P20:   upd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_V1]) + prod_w);
      S_P21:   upd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_X0H0]) + prod_w);
      S_P22:   upd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_X1H0]) + prod_w);
      S_P23:   upd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_X0H1]) + prod_w);
      default: upd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_X1H1]) + prod_w);
    endcase
  end

  // Bias updates run beside the weight updates
  mlpbp_pkg::sat_res_t bupd;
  always_comb begin
    unique case (state_r)
      S_P20:   bupd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_B0])
                                          + mlpbp_pkg::acc_t'(kh0_r));
      default: bupd = mlpbp_pkg::sat_word(mlpbp_pkg::acc_t'(wt_r[mlpbp_pkg::WI_B1])
                                          + mlpbp_pkg::acc_t'(kh1_r));
    endcase
  end

  // Sequencer, weights and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lr_r        <= mlpbp_pkg::LR_RESET;
      for (int i = 0; i < mlpbp_pkg::NUM_WEIGHTS; i++) wt_r[i] <= '0;
    end else begin
      if (cfg_ch.valid) lr_r <= cfg_ch.learning_rate;
      // Drop the result once taken, unless a new one is loaded this cycle
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r <= in_mode;
            x0_r   <= in_ch.x_first;
            x1_r   <= in_ch.x_second;
            tgt_r  <= (in_ch.target > 13'(mlpbp_pkg::SIG_ONE)) ? mlpbp_pkg::SIG_ONE
                                                                : in_ch.target;
            sat_r  <= 1'b0;
            if (in_mode == mlpbp_pkg::MODE_LOAD && in_ch.weight_index <= mlpbp_pkg::WI_C) begin
              wt_r[in_ch.weight_index] <= in_ch.weight_value;
            end
            if (in_mode == mlpbp_pkg::MODE_TRAIN || in_mode == mlpbp_pkg::MODE_INFER) begin
              state_r <= S_P0;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_P0: state_r <= S_P1;
        S_P1: begin
          acc_r   <= prod_r;
          state_r <= S_P2;
        end
        S_P2: begin
          h0_r    <= sig_y;
          sat_r   <= sat_r | sig_flag;
          state_r <= S_P3;
        end
        S_P3: begin
          acc_r   <= prod_r;
          state_r <= S_P4;
        end
        S_P4: begin
          h1_r    <= sig_y;
          sat_r   <= sat_r | sig_flag;
          state_r <= S_P5;
        end
        S_P5: begin
          acc_r   <= prod_r;
          state_r <= S_P6;
        end
        S_P6: begin
          o_r     <= sig_y;
          sat_r   <= sat_r | sig_flag;
          state_r <= (mode_r == mlpbp_pkg::MODE_TRAIN) ? S_P7 : S_DONE;
        end
        S_P7: state_r <= S_P8;
        S_P8: begin
          dso_r   <= prod_f;
          state_r <= S_P9;
        end
        S_P9: begin
          dsh0_r  <= prod_f;
          state_r <= S_P10;
        end
        S_P10: begin
          dout_r  <= prod_f;
          state_r <= S_P11;
        end
        S_P11: begin
          dsh1_r  <= prod_f;
          state_r <= S_P12;
        end
        S_P12: begin
          t0_r    <= prod_f;
          state_r <= S_P13;
        end
        S_P13: begin
          t1_r    <= prod_f;
          state_r <= S_P14;
        end
        S_P14: begin
          dh0_r   <= prod_f;
          state_r <= S_P15;
        end
        S_P15: begin
          dh1_r   <= prod_f;
          state_r <= S_P16;
        end
        S_P16: begin
          ko_r    <= prod_l;
          state_r <= S_P17;
        end
        S_P17: begin
          kh0_r   <= prod_l;
          state_r <= S_P18;
        end
        S_P18: begin
          kh1_r                   <= prod_l;
          wt_r[mlpbp_pkg::WI_C]   <= upd.val;
          sat_r                   <= sat_r | upd.flag;
          state_r                 <= S_P19;
        end
        S_P19: begin
          wt_r[mlpbp_pkg::WI_V0]  <= upd.val;
          sat_r                   <= sat_r | upd.flag;
          state_r                 <= S_P20;
        end
        S_P20: begin
          wt_r[mlpbp_pkg::WI_V1]  <= upd.val;
          wt_r[mlpbp_pkg::WI_B0]  <= bupd.val;
          sat_r                   <= sat_r | upd.flag | bupd.flag;
          state_r                 <= S_P21;
        end
        S_P21: begin
          wt_r[mlpbp_pkg::WI_X0H0] <= upd.val;
          sat_r                    <= sat_r | upd.flag;
          state_r                  <= S_P22;
        end
        S_P22: begin
          wt_r[mlpbp_pkg::WI_X1H0] <= upd.val;
          wt_r[mlpbp_pkg::WI_B1]   <= bupd.val;
          sat_r                    <= sat_r | upd.flag | bupd.flag;
          state_r                  <= S_P23;
        end
        S_P23: begin
          wt_r[mlpbp_pkg::WI_X0H1] <= upd.val;
          sat_r                    <= sat_r | upd.flag;
          state_r                  <= S_P24;
        end
        S_P24: begin
          wt_r[mlpbp_pkg::WI_X1H1] <= upd.val;
          sat_r                    <= sat_r | upd.flag;
          state_r                  <= S_DONE;
        end
        S_DONE: begin
          // Hand over once the result register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            if (mode_r == mlpbp_pkg::MODE_TRAIN || mode_r == mlpbp_pkg::MODE_INFER) begin
              res_o_r   <= o_r;
              res_sat_r <= sat_r;
            end else begin
              res_o_r   <= '0;
              res_sat_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.net_output = res_o_r;
  assign out_ch.saturated  = res_sat_r;

  assign zero_done = state_r == S_DONE && !out_valid_r &&
                     (mode_r == mlpbp_pkg::MODE_LOAD || mode_r == mlpbp_pkg::MODE_NONE);
  assign busy      = state_r != S_IDLE && state_r != S_DONE;

  `ASSERT_IMPL(a_out_range, out_valid_r, res_o_r <= mlpbp_pkg::SIG_ONE, "net_output above one")
  `ASSERT_NEXT(a_load_zero, zero_done, out_valid_r && res_o_r == '0 && !res_sat_r, "load not zero")
  `ASSERT_NEXT(a_busy_not_ready, busy, !in_ch.ready || state_r == S_IDLE, "accepting while busy")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the 2-2-1 online backprop trainer.
// Depends on mlpbp_pkg, the mlpbp_if channel interfaces and the trainer top level.
// Predicts each result from its own network model; compares in arrival order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlpbp_pkg::*;

  typedef struct {
    mode_t    mode;
    in_word_t x_first;
    in_word_t x_second;
    logic [12:0] target;
    widx_t    widx;
    in_word_t wval;
  } request_t;

  typedef struct {
    sig_t net;
    logic sat;
  } outcome_t;

  logic clk;
  logic rst_n;

  mlpbp_in_if  in_bus();
  mlpbp_out_if out_bus();
  mlpbp_cfg_if cfg_bus();

  mlp_online_backprop_trainer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source),
    .cfg_ch (cfg_bus.sink)
  );

  request_t pending_reqs[$];
  outcome_t expected_outs[$];
  request_t cur_req;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       mismatches;

  // Network model state
  longint   sig_lut[SIGMOID_ENTRIES];
  longint   w_hid[4];
  longint   b_hid[2];
  longint   w_out[2];
  longint   b_out;
  longint   step_size;

  function automatic void build_lut();
    longint num, sum;
    longint unsigned mag, y, t, e, den, one;
    one = 64'd1 << 30;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      num = longint'(16 * i - 8 * SIGMOID_ENTRIES);
      mag = (num < 0) ? -num : num;
      y   = (mag << 26) / SIGMOID_ENTRIES;
      t   = one;
      sum = one;
      for (int k = 1; k <= 16; k++) begin
        t = ((t * y) >> 30) / k;
        sum = (k % 2 == 1) ? sum - longint'(t) : sum + longint'(t);
      end
      e = sum;
      for (int k = 0; k < 4; k++) e = (e * e) >> 30;
      den = one + e;
      if (num >= 0) sig_lut[i] = ((64'd1 << FRAC_BITS) * one + den / 2) / den;
      else          sig_lut[i] = ((64'd1 << FRAC_BITS) * e + den / 2) / den;
    end
  endfunction

  function automatic longint clip(longint v, inout bit flag);
    longint hi, lo;
    hi = (64'sd1 <<< (WORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1;
      return hi;
    end
    if (v < lo) begin
      flag = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint squash(longint s);
    longint off, idx;
    off = s + (64'sd8 <<< FRAC_BITS);
    if (off < 0) return sig_lut[0];
    idx = (off * SIGMOID_ENTRIES) >>> (FRAC_BITS + 4);
    if (idx >= SIGMOID_ENTRIES) idx = SIGMOID_ENTRIES - 1;
    return sig_lut[idx];
  endfunction

  function automatic longint slope(longint y);
    return (y * ((64'sd1 <<< FRAC_BITS) - y)) >>> FRAC_BITS;
  endfunction

  // Apply one request to the model and return the result it produces
  function automatic outcome_t train_step(request_t r);
    outcome_t res;
    bit       flag;
    longint   x[2], h[2], kh[2];
    longint   net, o, tgt, dout, dh, ko;
    flag = 0;
    res.net = '0;
    res.sat = 1'b0;
    if (r.mode == MODE_LOAD) begin
      if (r.widx <= WI_X1H1) w_hid[r.widx] = longint'(r.wval);
      else if (r.widx <= WI_B1) b_hid[r.widx - WI_B0] = longint'(r.wval);
      else if (r.widx <= WI_V1) w_out[r.widx - WI_V0] = longint'(r.wval);
      else if (r.widx == WI_C) b_out = longint'(r.wval);
      return res;
    end
    if (r.mode == MODE_NONE) return res;
    x[0] = longint'(r.x_first);
    x[1] = longint'(r.x_second);
    for (int j = 0; j < 2; j++)
      h[j] = squash(clip(((x[0] * w_hid[j] + x[1] * w_hid[2 + j]) >>> FRAC_BITS)
                         + b_hid[j], flag));
    net = ((h[0] * w_out[0] + h[1] * w_out[1]) >>> FRAC_BITS) + b_out;
    o = squash(clip(net, flag));
    if (r.mode == MODE_TRAIN) begin
      tgt = longint'(r.target);
      if (tgt > (64'sd1 <<< FRAC_BITS)) tgt = 64'sd1 <<< FRAC_BITS;
      dout = ((tgt - o) * slope(o)) >>> FRAC_BITS;
      for (int j = 0; j < 2; j++) begin
        dh = (((dout * w_out[j]) >>> FRAC_BITS) * slope(h[j])) >>> FRAC_BITS;
        kh[j] = (step_size * dh) >>> LR_FRAC;
      end
      ko = (step_size * dout) >>> LR_FRAC;
      for (int j = 0; j < 2; j++)
        w_out[j] = clip(w_out[j] + ((ko * h[j]) >>> FRAC_BITS), flag);
      b_out = clip(b_out + ko, flag);
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++)
          w_hid[2 * i + j] = clip(w_hid[2 * i + j] + ((kh[j] * x[i]) >>> FRAC_BITS), flag);
        b_hid[j] = clip(b_hid[j] + kh[j], flag);
      end
    end
    res.net = sig_t'(o);
    res.sat = flag;
    return res;
  endfunction

  function automatic request_t mk_req(mode_t m, int x0, int x1, int tgt, int idx, int val);
    request_t r;
    r.mode = m;
    r.x_first = in_word_t'(x0);
    r.x_second = in_word_t'(x1);
    r.target = 13'(tgt);
    r.widx = widx_t'(idx);
    r.wval = in_word_t'(val);
    return r;
  endfunction

  function automatic in_word_t rand_input();
    if ($urandom_range(3) == 0) return in_word_t'($urandom);
    return in_word_t'($urandom_range(16384) - 8192);
  endfunction

  // Mostly training with random content; loads keep the weights moving
  function automatic request_t rand_req();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.x_first  = rand_input();
    r.x_second = rand_input();
    r.target   = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(4096));
    r.widx     = ($urandom_range(9) == 0) ? widx_t'($urandom) : widx_t'($urandom_range(8));
    r.wval     = ($urandom_range(2) == 0) ? in_word_t'($urandom)
                                         : in_word_t'($urandom_range(24576) - 12288);
    if (pick < 12)      r.mode = MODE_LOAD;
    else if (pick < 27) r.mode = MODE_INFER;
    else if (pick < 30) r.mode = MODE_NONE;
    else                r.mode = MODE_TRAIN;
    return r;
  endfunction

  // Clock, and known values on every input from time zero
  initial begin
    clk = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_NONE;
    in_bus.x_first = '0;
    in_bus.x_second = '0;
    in_bus.target = '0;
    in_bus.weight_index = '0;
    in_bus.weight_value = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.learning_rate = '0;
    forever #5 clk = ~clk;
  end

  // Request driver: predict on acceptance, then present the next request
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      nv = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        expected_outs.push_back(train_step(cur_req));
        nv = 1'b0;
      end
      if (!nv && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        nv = 1'b1;
        in_bus.mode         <= cur_req.mode;
        in_bus.x_first      <= cur_req.x_first;
        in_bus.x_second     <= cur_req.x_second;
        in_bus.target       <= cur_req.target;
        in_bus.weight_index <= cur_req.widx;
        in_bus.weight_value <= cur_req.wval;
      end
      in_bus.valid <= nv;
    end
  end

  // Result monitor: random back-pressure, compare with the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_outs.size() == 0) begin
          $display("%0t: unexpected result net_output=%0d saturated=%0b",
                   $realtime, out_bus.net_output, out_bus.saturated);
          mismatches++;
        end else begin
          want = expected_outs.pop_front();
          if (out_bus.net_output !== want.net) begin
            $display("%0t: net_output expected %0d actual %0d",
                     $realtime, want.net, out_bus.net_output);
            mismatches++;
          end
          if (out_bus.saturated !== want.sat) begin
            $display("%0t: saturated expected %0b actual %0b",
                     $realtime, want.sat, out_bus.saturated);
            mismatches++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold the sender until every pending request has its result, then settle
  task automatic drain();
    while (pending_reqs.size() > 0 || in_bus.valid || expected_outs.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_step(int v);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.learning_rate <= lr_t'(v);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    step_size = longint'(v);
  endtask

  // Stimulus sequence
  initial begin
    int rates[5];
    int counts[5];
    rates  = '{4096, 0, 8191, 0, 1};
    counts = '{250, 150, 200, 300, 250};
    rates[3] = $urandom_range(8191);
    mismatches = 0;
    send_idle_pct = 15;
    recv_idle_pct = 50;
    build_lut();
    for (int i = 0; i < 4; i++) w_hid[i] = 0;
    b_hid = '{0, 0};
    w_out = '{0, 0};
    b_out = 0;
    step_size = longint'(LR_RESET);
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero network, weight extremes, all modes, odd cases
    pending_reqs.push_back(mk_req(MODE_INFER, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(MODE_TRAIN, 4096, -4096, 4096, 0, 0));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_X0H0, 32767));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_X0H1, -32768));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_X1H0, 32767));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_X1H1, -32768));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_B0, 32767));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_B1, -32768));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_V0, 32767));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_V1, -32768));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_C, 32767));
    pending_reqs.push_back(mk_req(MODE_INFER, 32767, -32768, 0, 0, 0));
    pending_reqs.push_back(mk_req(MODE_INFER, -32768, 32767, 0, 0, 0));
    pending_reqs.push_back(mk_req(MODE_TRAIN, 32767, 32767, 8191, 0, 0));
    pending_reqs.push_back(mk_req(MODE_TRAIN, -32768, -32768, 0, 0, 0));
    pending_reqs.push_back(mk_req(MODE_NONE, 1234, -1234, 4096, WI_C, 777));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_C + 1, 4096));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, 15, -1));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_V0, 2048));
    pending_reqs.push_back(mk_req(MODE_LOAD, 0, 0, 0, WI_C, -1024));
    pending_reqs.push_back(mk_req(MODE_TRAIN, 4096, 0, 4097, 0, 0));
    pending_reqs.push_back(mk_req(MODE_TRAIN, 0, 4096, 4096, 0, 0));
    pending_reqs.push_back(mk_req(MODE_INFER, 4096, 4096, 0, 0, 0));
    drain();

    // Random phases, each under its own step size
    for (int p = 0; p < 5; p++) begin
      if (p == 1) begin
        send_idle_pct = 50;
        recv_idle_pct = 15;
      end else if (p == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_step(rates[p]);
      for (int n = 0; n < counts[p]; n++) pending_reqs.push_back(rand_req());
      drain();
    end

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
